@@ rtl/tvenc_pkg.sv @@
// ----------------------------------------------------------------------------
// tvenc_pkg: shared types and helpers for the trace record varint encoder
// Record descriptor, queue status and the prefix-varint byte functions.
// ----------------------------------------------------------------------------
`default_nettype none

package tvenc_pkg;

  localparam int unsigned MaxValues         = 4;
  localparam int unsigned QueueDepthDefault = 2;

  // Thresholds of the prefix code
  localparam logic [31:0] Lim1 = 32'h0000_0080;
  localparam logic [31:0] Lim2 = 32'h0000_4000;
  localparam logic [31:0] Lim3 = 32'h0020_0000;
  localparam logic [31:0] Lim4 = 32'h1000_0000;

  // Leading-byte prefixes
  localparam logic [7:0] Pfx2 = 8'h80;
  localparam logic [7:0] Pfx3 = 8'hC0;
  localparam logic [7:0] Pfx4 = 8'hE0;
  localparam logic [7:0] Pfx5 = 8'hF0;

  // One classified record, as it travels through the queue
  typedef struct packed {
    logic [7:0]                 event_code;
    logic [2:0]                 count;   // saturated, 0..4
    logic [MaxValues-1:0][31:0] values;
    logic [MaxValues-1:0][2:0]  lens;    // encoded length, 1..5 bytes
  } record_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Encoded length of a value in bytes
  function automatic logic [2:0] varint_len(input logic [31:0] v);
    logic [2:0] len;
    if (v < Lim1) begin
      len = 3'd1;
    end else if (v < Lim2) begin
      len = 3'd2;
    end else if (v < Lim3) begin
      len = 3'd3;
    end else if (v < Lim4) begin
      len = 3'd4;
    end else begin
      len = 3'd5;
    end
    return len;
  endfunction

  // Byte idx (0 = first sent) of the big-endian prefix form of v
  function automatic logic [7:0] varint_byte(input logic [31:0] v, input logic [2:0] len,
                                             input logic [2:0] idx);
    logic [2:0] rem;
    logic [7:0] b;
    logic [7:0] pfx;
    rem = len - idx - 3'd1;
    case (rem)
      3'd0:    b = v[7:0];
      3'd1:    b = v[15:8];
      3'd2:    b = v[23:16];
      3'd3:    b = v[31:24];
      default: b = 8'h00;
    endcase
    case (len)
      3'd2:    pfx = Pfx2;
      3'd3:    pfx = Pfx3;
      3'd4:    pfx = Pfx4;
      3'd5:    pfx = Pfx5;
      default: pfx = 8'h00;
    endcase
    if (idx == 3'd0) begin
      b = b | pfx;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tvenc_front.sv @@
// ----------------------------------------------------------------------------
// tvenc_front: command intake and classification
// Saturates the value count, sizes each value and pushes the record.
// ----------------------------------------------------------------------------
`default_nettype none

module tvenc_front (
  input  wire logic                 start_i,
  input  wire logic [7:0]           event_code_i,
  input  wire logic [2:0]           value_count_i,
  input  wire logic [31:0]          value0_i,
  input  wire logic [31:0]          value1_i,
  input  wire logic [31:0]          value2_i,
  input  wire logic [31:0]          value3_i,
  input  wire tvenc_pkg::q_status_t status_i,
  output logic                      busy_o,
  output logic                      push_o,
  output tvenc_pkg::record_t        rec_o
);

  // Hold off new commands while the queue is full
  assign busy_o = status_i.full;
  assign push_o = start_i & ~status_i.full;

  // Classify the record
  always_comb begin
    rec_o.event_code = event_code_i;
    rec_o.count      = (value_count_i > 3'(tvenc_pkg::MaxValues))
                       ? 3'(tvenc_pkg::MaxValues) : value_count_i;
    rec_o.values[0]  = value0_i;
    rec_o.values[1]  = value1_i;
    rec_o.values[2]  = value2_i;
    rec_o.values[3]  = value3_i;
    rec_o.lens[0]    = tvenc_pkg::varint_len(value0_i);
    rec_o.lens[1]    = tvenc_pkg::varint_len(value1_i);
    rec_o.lens[2]    = tvenc_pkg::varint_len(value2_i);
    rec_o.lens[3]    = tvenc_pkg::varint_len(value3_i);
  end

endmodule

`default_nettype wire

@@ rtl/tvenc_queue.sv @@
// ----------------------------------------------------------------------------
// tvenc_queue: record queue between intake and serializer
// Small circular buffer with a fill count; head is visible combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module tvenc_queue #(
  parameter int unsigned Depth = tvenc_pkg::QueueDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire tvenc_pkg::record_t  wdata_i,
  input  wire logic                pop_i,
  output tvenc_pkg::record_t       rdata_o,
  output tvenc_pkg::q_status_t     status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tvenc_pkg::record_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign rdata_o        = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the record
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tvenc_back.sv @@
// ----------------------------------------------------------------------------
// tvenc_back: byte serializer
// Walks the head record tag first, then each value byte by byte, one beat
// per cycle, and loads the next record right behind the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tvenc_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire tvenc_pkg::record_t   head_i,
  input  wire tvenc_pkg::q_status_t status_i,
  output logic                      pop_o,
  output logic                      result_valid_o,
  output logic [7:0]                out_byte_o,
  output logic                      last_byte_o
);

  tvenc_pkg::record_t cur_q, cur_d;
  logic               active_q, active_d;
  logic               tag_q, tag_d;
  logic [1:0]         vi_q, vi_d;
  logic [2:0]         bi_q, bi_d;
  logic               valid_q;
  logic [7:0]         byte_q, byte_d;
  logic               last_q, last_d;
  logic [31:0]        val;
  logic [2:0]         len;
  logic               len_end;

  assign val     = cur_q.values[vi_q];
  assign len     = cur_q.lens[vi_q];
  assign len_end = (bi_q == len - 3'd1);

  // Form the current byte and step through the record
  always_comb begin
    cur_d    = cur_q;
    active_d = active_q;
    tag_d    = tag_q;
    vi_d     = vi_q;
    bi_d     = bi_q;
    pop_o    = 1'b0;

    if (tag_q) begin
      byte_d = cur_q.event_code;
      last_d = (cur_q.count == 3'd0);
    end else begin
      byte_d = tvenc_pkg::varint_byte(val, len, bi_q);
      last_d = ({1'b0, vi_q} == cur_q.count - 3'd1) && len_end;
    end

    if (active_q && !last_d) begin
      if (tag_q) begin
        tag_d = 1'b0;
        vi_d  = '0;
        bi_d  = '0;
      end else if (len_end) begin
        vi_d = vi_q + 2'd1;
        bi_d = '0;
      end else begin
        bi_d = bi_q + 3'd1;
      end
    end else begin
      // Record done or idle: take the next one if queued
      if (!status_i.empty) begin
        pop_o    = 1'b1;
        cur_d    = head_i;
        active_d = 1'b1;
        tag_d    = 1'b1;
        vi_d     = '0;
        bi_d     = '0;
      end else begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tag_q    <= 1'b0;
      vi_q     <= '0;
      bi_q     <= '0;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      tag_q    <= tag_d;
      vi_q     <= vi_d;
      bi_q     <= bi_d;
      valid_q  <= active_q;
    end
  end

  // Register the beat payload
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign result_valid_o = valid_q;
  assign out_byte_o     = byte_q;
  assign last_byte_o    = last_q & valid_q;

endmodule

`default_nettype wire

@@ rtl/trace_record_varint_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// trace_record_varint_encoder_unit: trace record to prefix-varint byte stream
// Encodes a tag byte and zero to four 32-bit values as a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Command side: a record (event_code_i, value_count_i, value0_i..value3_i)
//   is taken at a rising edge with start_i high and busy_o low. A count above
//   four counts as four; a count of zero yields the tag byte alone.
//   Result side: one byte per beat on out_byte_o, marked by result_valid_o,
//   with last_byte_o on the final byte of each record. The receiver takes
//   every beat; it cannot stall the output.
//   Path: a record taken into an idle block passes the queue storage and the
//   serializer's record register before its tag byte leaves the byte register.
//   Stream: a record occupies the output for one beat per byte, 1 to 21 bytes
//   (tag plus up to four values of 1 to 5 bytes); queued records follow each
//   other without gap cycles. The byte serializer sets this rate; the record
//   queue (QueueDepth entries) lets the intake run ahead, and busy_o is high
//   while that queue is full.
//   Reset empties the queue and clears the output strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module trace_record_varint_encoder_unit #(
  parameter int unsigned QueueDepth = tvenc_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [7:0]  event_code_i,
  input  wire logic [2:0]  value_count_i,
  input  wire logic [31:0] value0_i,
  input  wire logic [31:0] value1_i,
  input  wire logic [31:0] value2_i,
  input  wire logic [31:0] value3_i,
  output logic             result_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             last_byte_o
);

  tvenc_pkg::record_t   push_rec;
  tvenc_pkg::record_t   head_rec;
  tvenc_pkg::q_status_t q_status;
  logic                 push;
  logic                 pop;

  // Intake and classification
  tvenc_front u_front (
    .start_i       (start_i),
    .event_code_i  (event_code_i),
    .value_count_i (value_count_i),
    .value0_i      (value0_i),
    .value1_i      (value1_i),
    .value2_i      (value2_i),
    .value3_i      (value3_i),
    .status_i      (q_status),
    .busy_o        (busy_o),
    .push_o        (push),
    .rec_o         (push_rec)
  );

  // Record queue
  tvenc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_rec),
    .pop_i    (pop),
    .rdata_o  (head_rec),
    .status_o (q_status)
  );

  // Byte serializer
  tvenc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_rec),
    .status_i       (q_status),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .out_byte_o     (out_byte_o),
    .last_byte_o    (last_byte_o)
  );

  // Never pop an empty queue
  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("record popped from empty queue");

  // Never push into a full queue
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("record pushed into full queue");

  // A record's bytes come out without gaps
  a_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_byte_o) |=> result_valid_o)
    else $error("gap inside a record byte stream");

  // A full queue means the serializer is streaming
  a_full_streams : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |=> result_valid_o)
    else $error("queue full while output idle");

endmodule

`default_nettype wire

@@ test/trace_record_varint_encoder_unit_checker.sv @@
// ----------------------------------------------------------------------------
// trace_record_varint_encoder_unit_checker: byte stream scoreboard
// Watches the record intake and the byte output of the encoder. It rebuilds
// the expected prefix-varint byte stream of every accepted record and
// compares each output beat against it, byte and last flag.
// ----------------------------------------------------------------------------

module trace_record_varint_encoder_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [7:0]  event_code_i,
  input  logic [2:0]  value_count_i,
  input  logic [31:0] value0_i,
  input  logic [31:0] value1_i,
  input  logic [31:0] value2_i,
  input  logic [31:0] value3_i,
  input  logic        result_valid_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_byte_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned records_o,
  output int unsigned bytes_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PrintCap = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } coded_beat_t;

  coded_beat_t expected_beats[$];
  coded_beat_t head_beat;

  int unsigned mismatch_count = 0;
  int unsigned record_count   = 0;
  int unsigned beat_count     = 0;
  int unsigned pending_count  = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = pending_count;
  assign records_o    = record_count;
  assign bytes_o      = beat_count;

  // Print one line per mismatch and count it; keep the log short
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PrintCap) begin
      $display("MISMATCH @%0t ns: %s", $time, msg);
    end
  endtask

  // Number of bytes that the prefix code uses for v
  function automatic int unsigned coded_length(input logic [31:0] v);
    int unsigned len;
    if (v < tvenc_pkg::Lim1) begin
      len = 1;
    end else if (v < tvenc_pkg::Lim2) begin
      len = 2;
    end else if (v < tvenc_pkg::Lim3) begin
      len = 3;
    end else if (v < tvenc_pkg::Lim4) begin
      len = 4;
    end else begin
      len = 5;
    end
    return len;
  endfunction

  // Queue the big-endian prefix form of v; mark its final byte if asked
  task automatic queue_varint(input logic [31:0] v, input logic ends_record);
    int unsigned len;
    logic [7:0]  lead;
    logic [31:0] shifted;
    coded_beat_t beat;
    int          k;
    len = coded_length(v);
    // Leading byte: prefix bits merged with the top payload bits
    case (len)
      1: lead = v[7:0];
      2: begin
        shifted = v >> 8;
        lead = tvenc_pkg::Pfx2 | shifted[7:0];
      end
      3: begin
        shifted = v >> 16;
        lead = tvenc_pkg::Pfx3 | shifted[7:0];
      end
      4: begin
        shifted = v >> 24;
        lead = tvenc_pkg::Pfx4 | shifted[7:0];
      end
      default: lead = tvenc_pkg::Pfx5;
    endcase
    beat.data = lead;
    beat.last = ends_record && (len == 1);
    expected_beats.push_back(beat);
    // Remaining payload bytes, most significant first
    for (k = int'(len) - 2; k >= 0; k--) begin
      shifted   = v >> (8 * k);
      beat.data = shifted[7:0];
      beat.last = ends_record && (k == 0);
      expected_beats.push_back(beat);
    end
  endtask

  // Queue every byte that one accepted record must produce
  task automatic queue_record(input logic [7:0] code, input logic [2:0] count,
                              input logic [31:0] v0, input logic [31:0] v1,
                              input logic [31:0] v2, input logic [31:0] v3);
    logic [3:0][31:0] vals;
    int unsigned      used;
    coded_beat_t      beat;
    int unsigned      i;
    vals = {v3, v2, v1, v0};
    // Saturate the value count at four
    used = (count > tvenc_pkg::MaxValues) ? tvenc_pkg::MaxValues : count;
    beat.data = code;
    beat.last = (used == 0);
    expected_beats.push_back(beat);
    for (i = 0; i < used; i++) begin
      queue_varint(vals[i], i == used - 1);
    end
  endtask

  // Compare output beats first, then take in the record of this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_i) begin
        beat_count++;
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected byte 0x%02h last=%0b", out_byte_i,
                                    last_byte_i));
        end else begin
          head_beat = expected_beats.pop_front();
          if (out_byte_i !== head_beat.data) begin
            report_mismatch($sformatf("byte 0x%02h, expected 0x%02h", out_byte_i,
                                      head_beat.data));
          end
          if (last_byte_i !== head_beat.last) begin
            report_mismatch($sformatf("last flag %0b, expected %0b (byte 0x%02h)",
                                      last_byte_i, head_beat.last, head_beat.data));
          end
        end
      end
      if (start_i && !busy_i) begin
        record_count++;
        queue_record(event_code_i, value_count_i, value0_i, value1_i, value2_i, value3_i);
      end
      pending_count = expected_beats.size();
    end
  end

endmodule

@@ test/trace_record_varint_encoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// trace_record_varint_encoder_unit_tb: testbench top for the varint encoder
// Sends directed records at the code boundaries, then random records with
// random idle bursts, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------

module trace_record_varint_encoder_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomItems  = 100;
  localparam int unsigned QuietTail    = 25;
  localparam int unsigned DrainPoint   = 60;
  localparam int unsigned TailCycles   = 10;

  // Length class of a random value
  typedef enum int unsigned {
    LenOne,
    LenTwo,
    LenThree,
    LenFour,
    LenFive
  } len_class_e;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [7:0]  event_code_i;
  logic [2:0]  value_count_i;
  logic [31:0] value0_i;
  logic [31:0] value1_i;
  logic [31:0] value2_i;
  logic [31:0] value3_i;
  logic        result_valid_o;
  logic [7:0]  out_byte_o;
  logic        last_byte_o;

  int unsigned fail_count;
  int unsigned bytes_pending;
  int unsigned records_taken;
  int unsigned bytes_seen;
  int unsigned cycle_count = 0;

  trace_record_varint_encoder_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .event_code_i   (event_code_i),
    .value_count_i  (value_count_i),
    .value0_i       (value0_i),
    .value1_i       (value1_i),
    .value2_i       (value2_i),
    .value3_i       (value3_i),
    .result_valid_o (result_valid_o),
    .out_byte_o     (out_byte_o),
    .last_byte_o    (last_byte_o)
  );

  trace_record_varint_encoder_unit_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .event_code_i   (event_code_i),
    .value_count_i  (value_count_i),
    .value0_i       (value0_i),
    .value1_i       (value1_i),
    .value2_i       (value2_i),
    .value3_i       (value3_i),
    .result_valid_i (result_valid_o),
    .out_byte_i     (out_byte_o),
    .last_byte_i    (last_byte_o),
    .fail_count_o   (fail_count),
    .pending_o      (bytes_pending),
    .records_o      (records_taken),
    .bytes_o        (bytes_seen)
  );

  // Free-running clock, 20 ns period
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("trace_record_varint_encoder_unit test failed");
      $finish;
    end
  end

  // Present one record and hold it until the intake takes the beat
  task automatic send_record(input logic [7:0] code, input logic [2:0] count,
                             input logic [31:0] v0, input logic [31:0] v1,
                             input logic [31:0] v2, input logic [31:0] v3);
    logic taken;
    start_i       <= 1'b1;
    event_code_i  <= code;
    value_count_i <= count;
    value0_i      <= v0;
    value1_i      <= v1;
    value2_i      <= v2;
    value3_i      <= v3;
    // busy_o is stable from the falling edge to the next rising edge
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Drop start for a burst of idle cycles
  task automatic idle_sender(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop start and hold off until every expected byte has arrived
  task automatic drain_output();
    start_i <= 1'b0;
    do @(negedge clk_i); while (bytes_pending != 0);
    @(posedge clk_i);
  endtask

  // Random value, spread over the five code lengths and their edges
  function automatic logic [31:0] random_value();
    len_class_e cls;
    logic [31:0] v;
    cls = len_class_e'($urandom_range(LenFive));
    case (cls)
      LenOne:   v = $urandom_range(32'h0000_007F, 32'h0000_0000);
      LenTwo:   v = $urandom_range(32'h0000_3FFF, 32'h0000_0080);
      LenThree: v = $urandom_range(32'h001F_FFFF, 32'h0000_4000);
      LenFour:  v = $urandom_range(32'h0FFF_FFFF, 32'h0020_0000);
      default:  v = $urandom_range(32'hFFFF_FFFF, 32'h1000_0000);
    endcase
    // Now and then snap to the lower or upper edge of the class
    if ($urandom_range(7) == 0) begin
      case (cls)
        LenOne:   v = ($urandom_range(1) != 0) ? 32'h0000_007F : 32'h0000_0000;
        LenTwo:   v = ($urandom_range(1) != 0) ? 32'h0000_3FFF : 32'h0000_0080;
        LenThree: v = ($urandom_range(1) != 0) ? 32'h001F_FFFF : 32'h0000_4000;
        LenFour:  v = ($urandom_range(1) != 0) ? 32'h0FFF_FFFF : 32'h0020_0000;
        default:  v = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h1000_0000;
      endcase
    end
    return v;
  endfunction

  initial begin
    logic [2:0] count;
    int unsigned n;

    start_i       <= 1'b0;
    rst_ni        <= 1'b0;
    event_code_i  <= 8'h00;
    value_count_i <= 3'd1;
    value0_i      <= 32'h0;
    value1_i      <= 32'h0;
    value2_i      <= 32'h0;
    value3_i      <= 32'h0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every code boundary, tag only, saturated counts
    send_record(8'h00, 3'd1, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_record(8'hFF, 3'd1, 32'h0000_007F, 32'h0, 32'h0, 32'h0);
    send_record(8'h4D, 3'd1, 32'h0000_0080, 32'h0, 32'h0, 32'h0);
    send_record(8'h46, 3'd1, 32'h0000_3FFF, 32'h0, 32'h0, 32'h0);
    send_record(8'h52, 3'd1, 32'h0000_4000, 32'h0, 32'h0, 32'h0);
    idle_sender(3);
    send_record(8'h01, 3'd1, 32'h001F_FFFF, 32'h0, 32'h0, 32'h0);
    send_record(8'h02, 3'd1, 32'h0020_0000, 32'h0, 32'h0, 32'h0);
    send_record(8'h03, 3'd1, 32'h0FFF_FFFF, 32'h0, 32'h0, 32'h0);
    send_record(8'h04, 3'd1, 32'h1000_0000, 32'h0, 32'h0, 32'h0);
    send_record(8'h05, 3'd1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
    send_record(8'hA5, 3'd0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF);
    send_record(8'h80, 3'd2, 32'h0000_007F, 32'h0000_0080, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_record(8'h7F, 3'd3, 32'h0000_3FFF, 32'h0000_4000, 32'hFFFF_FFFF, 32'h0);
    send_record(8'hFF, 3'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_record(8'h10, 3'd4, 32'h0000_0000, 32'h001F_FFFF, 32'h0020_0000, 32'h1000_0000);
    send_record(8'h20, 3'd5, 32'h0000_0001, 32'h0000_0100, 32'h0001_0000, 32'h0100_0000);
    send_record(8'h30, 3'd6, 32'h8000_0000, 32'h0FFF_FFFF, 32'h0000_3FFF, 32'h0000_007F);
    send_record(8'h40, 3'd7, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_4000, 32'h0000_0080);
    send_record(8'hAA, 3'd2, 32'h0000_2AAA, 32'h0015_5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_record(8'h55, 3'd3, 32'h0AAA_AAAA, 32'h0000_0055, 32'hF0F0_F0F0, 32'hFFFF_FFFF);
    drain_output();

    // Random records: mostly one to four values, some odd counts
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if ($urandom_range(3) == 0) begin
        count = 3'($urandom_range(7));
      end else begin
        count = 3'($urandom_range(4, 1));
      end
      send_record(8'($urandom_range(255)), count, random_value(), random_value(),
                  random_value(), random_value());
      // Idle bursts, none over the closing stretch
      if (i < RandomItems - QuietTail && $urandom_range(3) == 0) begin
        n = $urandom_range(14, 1);
        idle_sender(n);
      end
      if (i == DrainPoint) begin
        drain_output();
      end
    end

    // Let the last bytes come out, then settle
    start_i <= 1'b0;
    do @(negedge clk_i); while (bytes_pending != 0);
    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);

    $display("Sent %0d records, checked %0d output bytes.", records_taken, bytes_seen);
    $display("Covered tag-only and saturated counts, all five code lengths and their edges.");
    if (fail_count == 0 && bytes_pending == 0) begin
      $display("trace_record_varint_encoder_unit test passed");
    end else begin
      $display("trace_record_varint_encoder_unit test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tvenc_pkg.sv
rtl/tvenc_front.sv
rtl/tvenc_queue.sv
rtl/tvenc_back.sv
rtl/trace_record_varint_encoder_unit.sv
test/trace_record_varint_encoder_unit_checker.sv
test/trace_record_varint_encoder_unit_tb.sv
